FILE: hdl/srtm_pkg.sv
// Shared types and constants for the SPI register transaction master.
// Used by the front classifier, the job queue, the serial engine and the top.
package srtm_pkg;

  // Largest data byte count a request may ask for (1 to 4, capped by the 32-bit data fields)
  localparam int unsigned MaxDataBytes = 4;
  localparam int unsigned DataBytesCap = (MaxDataBytes < 4) ? MaxDataBytes : 4;
  localparam logic [2:0]  MaxBytesW    = 3'(DataBytesCap);

  // Depth of the queue between front and back
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueueAw    = 1;

  // Mode codes on the input word
  localparam logic [2:0] ModeNone  = 3'd0;
  localparam logic [2:0] ModeWrite = 3'd1;
  localparam logic [2:0] ModeRead  = 3'd2;
  localparam logic [2:0] ModeCmd   = 3'd3;
  localparam logic [2:0] ModeReset = 3'd4;

  // Reset train: 32 ones
  localparam logic [39:0] ResetTrain = {32'hFFFF_FFFF, 8'h00};
  localparam logic [5:0]  ResetBits  = 6'd32;
  localparam logic [5:0]  CmdBits    = 6'd8;

  // Pin levels {chip select, clock, data out}
  localparam logic [2:0] PinsIdle = 3'b111;
  localparam logic [2:0] PinsHeld = 3'b011;

  typedef enum logic [2:0] {
    REQ_NONE,
    REQ_WRITE,
    REQ_READ,
    REQ_CMD,
    REQ_RESET
  } srtm_req_e;

  typedef enum logic [5:0] {
    PH_IDLE     = 6'b000001,
    PH_WRITE    = 6'b000010,
    PH_RD_CMD   = 6'b000100,
    PH_RD_DATA  = 6'b001000,
    PH_KEEP_LOW = 6'b010000,
    PH_WAIT     = 6'b100000
  } srtm_phase_e;

  typedef struct packed {
    logic [2:0]  mode;
    logic [7:0]  command_byte;
    logic [2:0]  byte_count;
    logic [31:0] write_data;
    logic        wait_ready;
    logic        miso;
  } srtm_in_t;

  typedef struct packed {
    logic        chip_select_n;
    logic        serial_clock;
    logic        serial_out;
    logic        busy_res;
    logic        done_res;
    logic [31:0] read_word;
  } srtm_out_t;

  // Classified tick, as queued for the engine
  typedef struct packed {
    srtm_req_e   req;
    logic [39:0] out_shift;
    logic [5:0]  init_bits;
    logic [5:0]  data_bits;
    logic        wait_start;
    logic        miso;
  } srtm_job_t;

endpackage

FILE: hdl/srtm_front.sv
// Front classifier: decodes the mode, clamps the byte count and builds the
// initial shift word for one tick. Depends on srtm_pkg.
module srtm_front (
  input  srtm_pkg::srtm_in_t  item_i,
  output srtm_pkg::srtm_job_t job_o
);
  import srtm_pkg::*;

  logic [2:0] nbytes;
  logic [5:0] nbits;

  always_comb begin
    if (item_i.byte_count == 3'd0) begin
      nbytes = 3'd1;
    end else if (item_i.byte_count > MaxBytesW) begin
      nbytes = MaxBytesW;
    end else begin
      nbytes = item_i.byte_count;
    end
  end

  assign nbits = {nbytes, 3'b000};

  always_comb begin
    job_o            = '0;
    job_o.req        = REQ_NONE;
    job_o.miso       = item_i.miso;
    job_o.data_bits  = nbits;
    job_o.wait_start = 1'b0;
    unique case (item_i.mode)
      ModeWrite: begin
        job_o.req       = REQ_WRITE;
        job_o.init_bits = nbits + CmdBits;
        case (nbytes)
          3'd1:    job_o.out_shift = {item_i.command_byte, item_i.write_data[7:0], 24'h0};
          3'd2:    job_o.out_shift = {item_i.command_byte, item_i.write_data[15:0], 16'h0};
          3'd3:    job_o.out_shift = {item_i.command_byte, item_i.write_data[23:0], 8'h0};
          default: job_o.out_shift = {item_i.command_byte, item_i.write_data};
        endcase
      end
      ModeRead: begin
        job_o.req       = REQ_READ;
        job_o.init_bits = CmdBits;
        job_o.out_shift = {item_i.command_byte, 32'h0};
      end
      ModeCmd: begin
        job_o.req        = REQ_CMD;
        job_o.init_bits  = CmdBits;
        job_o.out_shift  = {item_i.command_byte, 32'h0};
        job_o.wait_start = item_i.wait_ready;
      end
      ModeReset: begin
        job_o.req       = REQ_RESET;
        job_o.init_bits = ResetBits;
        job_o.out_shift = ResetTrain;
      end
      default: job_o.req = REQ_NONE;
    endcase
  end

endmodule

FILE: hdl/srtm_queue.sv
// Short queue of classified ticks between the front and the serial engine.
// Depends on srtm_pkg.
module srtm_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  srtm_pkg::srtm_job_t push_job_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                empty_o,
  output srtm_pkg::srtm_job_t pop_job_o
);
  import srtm_pkg::*;

  srtm_job_t            mem_q [QueueDepth];
  logic [QueueAw-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QueueAw-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QueueAw:0]     count_q, count_d;

  assign full_o    = (count_q == (QueueAw+1)'(QueueDepth));
  assign empty_o   = (count_q == '0);
  assign pop_job_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

FILE: hdl/srtm_engine.sv
// Serial engine: steps the mode 3 bit sequencer one tick per job and holds
// the result word in an output register. Depends on srtm_pkg.
module srtm_engine (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                job_valid_i,
  input  srtm_pkg::srtm_job_t job_i,
  output logic                job_pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output srtm_pkg::srtm_out_t out_item_o
);
  import srtm_pkg::*;

  srtm_phase_e phase_q, phase_d;
  logic [5:0]  bits_q, bits_d;
  logic [5:0]  data_bits_q, data_bits_d;
  logic        high_q, high_d;
  logic [39:0] out_shift_q, out_shift_d;
  logic [31:0] in_shift_q, in_shift_d;
  logic [2:0]  pins_q, pins_d;
  logic        done;
  logic [31:0] word;
  logic        step;
  logic        out_valid_q;
  srtm_out_t   out_item_q;

  assign step      = job_valid_i && (!out_valid_q || !out_stall_i);
  assign job_pop_o = step;

  always_comb begin
    phase_d     = phase_q;
    bits_d      = bits_q;
    data_bits_d = data_bits_q;
    high_d      = high_q;
    out_shift_d = out_shift_q;
    in_shift_d  = in_shift_q;
    pins_d      = pins_q;
    done        = 1'b0;
    word        = '0;
    unique case (phase_q) inside
      PH_IDLE: begin
        if (job_i.req != REQ_NONE) begin
          high_d      = 1'b0;
          in_shift_d  = '0;
          bits_d      = job_i.init_bits;
          data_bits_d = job_i.data_bits;
          out_shift_d = job_i.out_shift;
          case (job_i.req)
            REQ_WRITE: phase_d = PH_WRITE;
            REQ_READ:  phase_d = PH_RD_CMD;
            default:   phase_d = PH_KEEP_LOW;
          endcase
          if (job_i.wait_start && job_i.miso) begin
            // hold pins until the converter pulls its data line low
            phase_d = PH_WAIT;
          end else begin
            pins_d      = {2'b00, job_i.out_shift[39]};
            out_shift_d = {job_i.out_shift[38:0], 1'b0};
          end
        end
      end
      PH_WAIT: begin
        if (!job_i.miso) begin
          phase_d     = PH_KEEP_LOW;
          pins_d      = {2'b00, out_shift_q[39]};
          out_shift_d = {out_shift_q[38:0], 1'b0};
          high_d      = 1'b0;
        end
      end
      PH_WRITE, PH_RD_CMD, PH_RD_DATA, PH_KEEP_LOW: begin
        if (!high_q) begin
          // high half: raise clock, sample in the read data part
          pins_d = pins_q | 3'b010;
          if (phase_q == PH_RD_DATA) begin
            in_shift_d = {in_shift_q[30:0], job_i.miso};
          end
          if (bits_q != '0) begin
            bits_d = bits_q - 1'b1;
          end
          high_d = 1'b1;
        end else if (bits_q != '0) begin
          high_d = 1'b0;
          if (phase_q == PH_RD_DATA) begin
            pins_d = 3'b000;
          end else begin
            pins_d      = {2'b00, out_shift_q[39]};
            out_shift_d = {out_shift_q[38:0], 1'b0};
          end
        end else if (phase_q == PH_RD_CMD) begin
          // command out: switch to the data part, MOSI held low
          bits_d     = data_bits_q;
          in_shift_d = '0;
          phase_d    = PH_RD_DATA;
          pins_d     = 3'b000;
          high_d     = 1'b0;
        end else begin
          pins_d = (phase_q == PH_KEEP_LOW) ? PinsHeld : PinsIdle;
          if (phase_q == PH_RD_DATA) begin
            word = in_shift_q;
          end
          done    = 1'b1;
          phase_d = PH_IDLE;
          bits_d  = '0;
          high_d  = 1'b0;
        end
      end
      default: phase_d = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      bits_q      <= '0;
      data_bits_q <= '0;
      high_q      <= 1'b0;
      out_shift_q <= '0;
      in_shift_q  <= '0;
      pins_q      <= PinsIdle;
      out_valid_q <= 1'b0;
    end else begin
      if (step) begin
        phase_q     <= phase_d;
        bits_q      <= bits_d;
        data_bits_q <= data_bits_d;
        high_q      <= high_d;
        out_shift_q <= out_shift_d;
        in_shift_q  <= in_shift_d;
        pins_q      <= pins_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_item_q.chip_select_n <= pins_d[2];
      out_item_q.serial_clock  <= pins_d[1];
      out_item_q.serial_out    <= pins_d[0];
      out_item_q.busy_res      <= (phase_d != PH_IDLE);
      out_item_q.done_res      <= done;
      out_item_q.read_word     <= word;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

FILE: hdl/spi_register_transaction_master.sv
// Top level of the SPI register transaction master: front classifier, job
// queue and serial engine. Depends on srtm_pkg and the three srtm modules.
//
// Usage:
//   Each input word is one half period of the serial clock. Drive in_valid_i
//   with the tick's mode, command, byte count, write data, wait flag and the
//   sampled MISO level; the word is taken when in_valid_i is high and
//   in_stall_o is low. Every input word yields exactly one result word with
//   the pin levels (chip select, clock, data out), busy, done and read data.
//   A result is taken when out_valid_o is high and out_stall_i is low.
// Path and throughput:
//   A taken word is written into the queue; the engine then pops it and
//   registers the result. One word is taken every cycle while in_stall_o is
//   low and no stalled result holds the engine; the rate is set by the
//   engine, which advances its bit sequencer once per word.
// Reset:
//   rst_ni clears the queue and the output valid flag and puts the engine in
//   idle with all pins high.
// Stall:
//   A stalled receiver holds the result; the two-entry queue absorbs words
//   until full, then in_stall_o rises.
module spi_register_transaction_master (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  srtm_pkg::srtm_in_t in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output srtm_pkg::srtm_out_t out_item_o
);
  import srtm_pkg::*;

  srtm_job_t front_job;
  srtm_job_t queue_job;
  logic      queue_full;
  logic      queue_empty;
  logic      queue_pop;
  logic      queue_push;

  assign in_stall_o = queue_full;
  assign queue_push = in_valid_i && !queue_full;

  srtm_front u_front (
    .item_i (in_item_i),
    .job_o  (front_job)
  );

  srtm_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (queue_push),
    .push_job_i (front_job),
    .full_o     (queue_full),
    .pop_i      (queue_pop),
    .empty_o    (queue_empty),
    .pop_job_o  (queue_job)
  );

  srtm_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (!queue_empty),
    .job_i       (queue_job),
    .job_pop_o   (queue_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

FILE: dv/spi_register_transaction_master_checker.sv
// Checker for the SPI register transaction master: watches both channels,
// predicts each result word from the accepted ticks and compares field by field.
// Depends on srtm_pkg for the word types and the mode and phase codes.
`timescale 1ns / 1ps

module spi_register_transaction_master_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_o,
  input  srtm_pkg::srtm_in_t  in_item_i,
  input  logic                out_valid_o,
  input  logic                out_stall_i,
  input  srtm_pkg::srtm_out_t out_item_o,
  output int unsigned         mismatches_o,
  output int unsigned         pending_o
);
  import srtm_pkg::*;

  localparam logic [2:0]  PinCs      = 3'b100;
  localparam logic [2:0]  PinSck     = 3'b010;
  localparam logic [2:0]  PinMosi    = 3'b001;
  localparam logic [2:0]  PinsLow    = 3'b000;
  localparam logic [5:0]  CmdLen     = 6'd8;
  localparam logic [5:0]  TrainLen   = 6'd32;
  localparam logic [39:0] TrainOnes  = {32'hFFFF_FFFF, 8'h00};

  // Serial engine state as the checker sees it
  srtm_phase_e seq_phase;
  logic [5:0]  bits_left;
  logic        in_high_half;
  logic [39:0] tx_shift;
  logic [31:0] rx_shift;
  logic [2:0]  pins;

  srtm_out_t   expected_ticks[$];
  int unsigned mismatch_total;

  task automatic drive_low_half();
    logic bit_out;
    bit_out = (seq_phase == PH_RD_DATA) ? 1'b0 : tx_shift[39];
    if (seq_phase != PH_RD_DATA) tx_shift = tx_shift << 1;
    pins = bit_out ? PinMosi : PinsLow;
    in_high_half = 1'b0;
  endtask

  task automatic drive_high_half(input logic miso);
    pins = pins | PinSck;
    if (seq_phase == PH_RD_DATA) rx_shift = {rx_shift[30:0], miso};
    if (bits_left != 0) bits_left = bits_left - 6'd1;
    in_high_half = 1'b1;
  endtask

  task automatic predict_tick(input srtm_in_t t, output srtm_out_t r);
    int unsigned nbytes;
    logic [31:0] keep_mask;
    logic [31:0] word;
    logic        done;
    word = '0;
    done = 1'b0;
    if (seq_phase == PH_IDLE) begin
      if (t.mode >= ModeWrite && t.mode <= ModeReset) begin
        nbytes = t.byte_count;
        if (nbytes < 1) nbytes = 1;
        if (nbytes > DataBytesCap) nbytes = DataBytesCap;
        in_high_half = 1'b0;
        rx_shift = '0;
        if (t.mode == ModeWrite) begin
          keep_mask = (nbytes >= 4) ? 32'hFFFF_FFFF : ((32'd1 << (8 * nbytes)) - 32'd1);
          seq_phase = PH_WRITE;
          bits_left = 6'(8 + 8 * nbytes);
          tx_shift = {t.command_byte, 32'h0} |
                     ({8'h00, t.write_data & keep_mask} << (32 - 8 * nbytes));
        end else if (t.mode == ModeRead) begin
          seq_phase = PH_RD_CMD;
          bits_left = CmdLen;
          tx_shift = {t.command_byte, 32'h0};
          // park the data bit count until the command is out
          rx_shift = 32'(8 * nbytes);
        end else if (t.mode == ModeCmd) begin
          seq_phase = PH_KEEP_LOW;
          bits_left = CmdLen;
          tx_shift = {t.command_byte, 32'h0};
        end else begin
          seq_phase = PH_KEEP_LOW;
          bits_left = TrainLen;
          tx_shift = TrainOnes;
        end
        if (t.mode == ModeCmd && t.wait_ready && t.miso) seq_phase = PH_WAIT;
        else drive_low_half();
      end
    end else if (seq_phase == PH_WAIT) begin
      if (!t.miso) begin
        seq_phase = PH_KEEP_LOW;
        drive_low_half();
      end
    end else if (!in_high_half) begin
      drive_high_half(t.miso);
    end else if (bits_left != 0) begin
      drive_low_half();
    end else if (seq_phase == PH_RD_CMD) begin
      bits_left = rx_shift[5:0];
      rx_shift = '0;
      seq_phase = PH_RD_DATA;
      drive_low_half();
    end else begin
      pins = (seq_phase == PH_KEEP_LOW) ? (PinSck | PinMosi) : (PinCs | PinSck | PinMosi);
      if (seq_phase == PH_RD_DATA) word = rx_shift;
      done = 1'b1;
      seq_phase = PH_IDLE;
      bits_left = '0;
      in_high_half = 1'b0;
    end
    r.chip_select_n = pins[2];
    r.serial_clock  = pins[1];
    r.serial_out    = pins[0];
    r.busy_res      = (seq_phase != PH_IDLE);
    r.done_res      = done;
    r.read_word     = word;
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatch_total++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    srtm_out_t want;
    srtm_out_t pred;
    if (!rst_ni) begin
      seq_phase = PH_IDLE;
      bits_left = '0;
      in_high_half = 1'b0;
      tx_shift = '0;
      rx_shift = '0;
      pins = PinCs | PinSck | PinMosi;
      expected_ticks.delete();
      mismatch_total = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_ticks.size() == 0) begin
          $error("result word with no expected word pending: %0h", out_item_o);
          mismatch_total++;
        end else begin
          want = expected_ticks.pop_front();
          check_field("chip_select_n", want.chip_select_n, out_item_o.chip_select_n);
          check_field("serial_clock", want.serial_clock, out_item_o.serial_clock);
          check_field("serial_out", want.serial_out, out_item_o.serial_out);
          check_field("busy_res", want.busy_res, out_item_o.busy_res);
          check_field("done_res", want.done_res, out_item_o.done_res);
          check_field("read_word", want.read_word, out_item_o.read_word);
        end
      end
      if (in_valid_i && !in_stall_o) begin
        predict_tick(in_item_i, pred);
        expected_ticks.push_back(pred);
      end
    end
    pending_o <= expected_ticks.size();
    mismatches_o <= mismatch_total;
  end

endmodule

FILE: dv/spi_register_transaction_master_tb.sv
// Testbench top for the SPI register transaction master: clock, reset, tick
// stimulus and result stall, with the checker beside the block.
// Depends on srtm_pkg, the block and spi_register_transaction_master_checker.
`timescale 1ns / 1ps

module spi_register_transaction_master_tb;
  import srtm_pkg::*;

  localparam int unsigned CycleLimit   = 200000;
  localparam int unsigned RandomTicks  = 450;
  localparam int unsigned LongHold     = 200;
  localparam int unsigned HoldAtResult = 300;
  localparam int unsigned PauseAfter   = 200;
  localparam int unsigned RecoverTicks = 80;
  localparam int unsigned DrainCycles  = 8;

  // MISO patterns for the ticks of one transaction
  localparam int unsigned MisoLow    = 0;
  localparam int unsigned MisoHigh   = 1;
  localparam int unsigned MisoRandom = 2;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  srtm_in_t    in_item_i;
  logic        out_valid_o;
  logic        out_stall_i;
  srtm_out_t   out_item_o;
  int unsigned mismatches;
  int unsigned pending;

  int unsigned ticks_sent, writes, reads, cmds, trains;
  bit          sender_steady, sink_steady;

  spi_register_transaction_master dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  spi_register_transaction_master_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_item_i    (in_item_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_item_o   (out_item_o),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic logic pick_miso(input int unsigned pattern);
    if (pattern == MisoLow) return 1'b0;
    if (pattern == MisoHigh) return 1'b1;
    return 1'($urandom_range(0, 1));
  endfunction

  function automatic srtm_in_t random_tick(input logic miso);
    srtm_in_t t;
    t.mode         = 3'($urandom_range(0, 7));
    t.command_byte = 8'($urandom);
    t.byte_count   = 3'($urandom_range(0, 7));
    t.write_data   = $urandom;
    t.wait_ready   = 1'($urandom_range(0, 1));
    t.miso         = miso;
    return t;
  endfunction

  // Called and returns at a falling edge; holds the word until it is taken.
  task automatic send_tick(input srtm_in_t t);
    int unsigned gap;
    if ($urandom_range(0, 63) == 0) sender_steady = !sender_steady;
    gap = sender_steady ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_item_i = t;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    ticks_sent++;
  endtask

  task automatic idle_tick(input logic [2:0] mode);
    srtm_in_t t;
    t = random_tick(1'($urandom_range(0, 1)));
    t.mode = mode;
    send_tick(t);
  endtask

  // One request tick, then the ticks that carry it to completion. A broken
  // sequence cuts the follow-up short and then idles long enough to resync.
  task automatic run_request(input logic [2:0] mode, input logic [7:0] cmd,
                             input logic [2:0] count, input logic [31:0] data,
                             input logic wait_ready, input int unsigned wait_len,
                             input int unsigned pattern, input bit broken);
    srtm_in_t    req;
    int unsigned nbytes, halves, fill;
    logic        holding;
    nbytes = (count == 0) ? 1 : ((count > 4) ? 4 : count);
    halves = (mode == ModeReset) ? 64 : ((mode == ModeCmd) ? 16 : 16 * (nbytes + 1));
    holding = (mode == ModeCmd) && wait_ready && (wait_len > 0);
    req.mode         = mode;
    req.command_byte = cmd;
    req.byte_count   = count;
    req.write_data   = data;
    req.wait_ready   = wait_ready;
    req.miso         = pick_miso(pattern);
    if (mode == ModeCmd && wait_ready) req.miso = holding;
    send_tick(req);
    if (holding) begin
      // keep MISO high while waiting, drop it on the first low half
      for (int i = 1; i <= wait_len; i++) send_tick(random_tick(i != wait_len));
    end
    fill = broken ? $urandom_range(0, halves - 1) : halves;
    for (int i = 0; i < fill; i++) send_tick(random_tick(pick_miso(pattern)));
    if (broken) begin
      repeat (RecoverTicks) idle_tick(ModeNone);
    end
    case (mode)
      ModeWrite: writes++;
      ModeRead:  reads++;
      ModeCmd:   cmds++;
      default:   trains++;
    endcase
  endtask

  // Result side: random stalls per word, one long hold-off to fill the queue.
  initial begin
    int unsigned taken, hold;
    out_stall_i = 1'b0;
    sink_steady = 1'b0;
    taken = 0;
    forever begin
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
      taken++;
      @(negedge clk_i);
      if ($urandom_range(0, 63) == 0) sink_steady = !sink_steady;
      if (taken == HoldAtResult) hold = LongHold;
      else hold = sink_steady ? 0 : $urandom_range(0, 7);
      if (hold > 0) begin
        out_stall_i = 1'b1;
        repeat (hold) @(negedge clk_i);
        out_stall_i = 1'b0;
      end
    end
  end

  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Timeout after %0d cycles, %0d words still expected", cycles, pending);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int unsigned random_start, pick;
    logic [2:0]  mode;
    bit          paused;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_item_i = '0;
    ticks_sent = 0;
    writes = 0;
    reads = 0;
    cmds = 0;
    trains = 0;
    sender_steady = 1'b0;
    paused = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: field extremes, every request, clamped counts, ignored flags
    run_request(ModeWrite, 8'hFF, 3'd4, 32'hFFFF_FFFF, 1'b0, 0, MisoRandom, 1'b0);
    run_request(ModeWrite, 8'h00, 3'd1, 32'h0000_0000, 1'b0, 0, MisoLow, 1'b0);
    run_request(ModeWrite, 8'h80, 3'd0, 32'hA5A5_5A5A, 1'b1, 0, MisoHigh, 1'b0);
    run_request(ModeWrite, 8'h01, 3'd7, 32'h1234_5678, 1'b0, 0, MisoRandom, 1'b0);
    run_request(ModeRead, 8'h58, 3'd4, 32'h0000_0000, 1'b0, 0, MisoHigh, 1'b0);
    run_request(ModeRead, 8'h40, 3'd1, 32'hFFFF_FFFF, 1'b1, 0, MisoLow, 1'b0);
    run_request(ModeRead, 8'h5C, 3'd0, 32'h0F0F_F0F0, 1'b0, 0, MisoRandom, 1'b0);
    run_request(ModeRead, 8'hC3, 3'd6, 32'h0000_0000, 1'b0, 0, MisoRandom, 1'b0);
    run_request(ModeCmd, 8'h5C, 3'd1, 32'h0000_0000, 1'b0, 0, MisoRandom, 1'b0);
    run_request(ModeCmd, 8'h58, 3'd2, 32'h0000_0000, 1'b1, 3, MisoRandom, 1'b0);
    run_request(ModeCmd, 8'hA5, 3'd1, 32'h0000_0000, 1'b1, 0, MisoRandom, 1'b0);
    run_request(ModeReset, 8'h00, 3'd0, 32'h0000_0000, 1'b1, 0, MisoHigh, 1'b0);
    for (int k = 5; k <= 7; k++) idle_tick(3'(k));
    run_request(ModeWrite, 8'h3C, 3'd2, 32'hDEAD_BEEF, 1'b0, 0, MisoRandom, 1'b1);

    random_start = ticks_sent;
    while (ticks_sent < random_start + RandomTicks) begin
      pick = $urandom_range(0, 99);
      mode = (pick < 30) ? ModeWrite : (pick < 60) ? ModeRead : (pick < 85) ? ModeCmd : ModeReset;
      run_request(mode, 8'($urandom), 3'($urandom_range(0, 7)), $urandom,
                  1'($urandom_range(0, 1)), $urandom_range(0, 4), MisoRandom,
                  $urandom_range(0, 11) == 0);
      repeat ($urandom_range(0, 3)) begin
        idle_tick(($urandom_range(0, 1) == 0) ? ModeNone : 3'($urandom_range(5, 7)));
      end
      if (!paused && ticks_sent >= random_start + PauseAfter) begin
        // let every expected word drain before going on
        in_valid_i = 1'b0;
        do @(posedge clk_i); while (pending != 0);
        @(negedge clk_i);
        paused = 1'b1;
      end
    end

    in_valid_i = 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (DrainCycles) @(posedge clk_i);
    $display("Drove %0d ticks: %0d writes, %0d reads, %0d command-only, %0d reset trains,",
             ticks_sent, writes, reads, cmds, trains);
    $display("with random gaps, stalls, ignored requests and %0d mismatches.", mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
